### rtl/temperature_excursion_classifier_assert.svh
// Assertion macros of the temperature excursion classifier checker.
`ifndef TEMPERATURE_EXCURSION_CLASSIFIER_ASSERT_SVH
`define TEMPERATURE_EXCURSION_CLASSIFIER_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define TEC_ASSERT_IMPLY(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("temperature excursion classifier: implication check failed");

// Next-cycle implication, disabled while reset is asserted.
`define TEC_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("temperature excursion classifier: next-cycle check failed");

`endif

### rtl/tec_pkg.sv
// Package with types, register indexes and constants of the excursion classifier.
`timescale 1ns / 1ps
`default_nettype none

package tec_pkg;

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 16;

    // Register indexes on the configuration port.
    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_BAND_LOW         = 3'd0,
        REG_BAND_HIGH        = 3'd1,
        REG_WARN_MARGIN      = 3'd2,
        REG_CRIT_MARGIN      = 3'd3,
        REG_ALLOWED_MINUTES  = 3'd4,
        REG_DELIVERY_MINUTES = 3'd5,
        REG_INTERVAL_MINUTES = 3'd6
    } tec_reg_idx_t;

    // Severity codes.
    typedef enum logic [1:0] {
        SEV_NORMAL   = 2'd0,
        SEV_WARNING  = 2'd1,
        SEV_HIGH     = 2'd2,
        SEV_CRITICAL = 2'd3
    } tec_sev_t;

    // Register reset values.
    localparam logic signed [15:0] BAND_LOW_RST         = 16'sd32;
    localparam logic signed [15:0] BAND_HIGH_RST        = 16'sd128;
    localparam logic [14:0]        WARN_MARGIN_RST      = 15'd16;
    localparam logic [14:0]        CRIT_MARGIN_RST      = 15'd48;
    localparam logic [15:0]        ALLOWED_MINUTES_RST  = 16'd30;
    localparam logic [15:0]        DELIVERY_MINUTES_RST = 16'd180;
    localparam logic [7:0]         INTERVAL_MINUTES_RST = 8'd30;

    // Grading rule constants.
    localparam logic [15:0] DELIVERY_CRIT_LIMIT = 16'd120;
    localparam logic [15:0] EVENTS_CRIT         = 16'd3;
    localparam logic [15:0] EVENTS_HIGH         = 16'd2;
    localparam logic [15:0] COUNT_SAT           = 16'hFFFF;

    typedef struct packed {
        logic signed [15:0] temperature;
        logic               first;
    } tec_in_t;

    typedef struct packed {
        logic signed [15:0] sample_temp;
        logic signed [15:0] highest_temp;
        logic signed [15:0] lowest_temp;
        logic [15:0]        excursion_total;
        logic [15:0]        excursion_events;
        logic [1:0]         severity;
    } tec_out_t;

    typedef struct packed {
        logic signed [15:0] band_low;
        logic signed [15:0] band_high;
        logic [14:0]        warn_margin;
        logic [14:0]        crit_margin;
        logic [15:0]        allowed_minutes;
        logic [15:0]        delivery_minutes;
        logic [7:0]         interval_minutes;
    } tec_cfg_t;

    typedef struct packed {
        logic signed [15:0] min_seen;
        logic signed [15:0] max_seen;
        logic               was_outside;
        logic [15:0]        minutes_accum;
        logic [15:0]        event_count;
    } tec_state_t;

endpackage

`default_nettype wire

### rtl/temperature_excursion_classifier.sv
// Top level of the temperature excursion classifier.
//
//   Channel   Direction  Handshake                    Payload
//   sample    in         sample_valid / sample_stall  tec_in_t  (temperature, first)
//   report    out        report_valid / report_stall  tec_out_t (statistics, severity)
//   cfg       in         cfg_write                    cfg_index, cfg_data
//
// A sample is taken into an input register; once the report register is free, the
// statistics update and the severity grading run in one pass and load the report
// register, whose valid flag then rises. The block takes one sample per cycle
// while the report side does not stall.
// The rate is set by the single statistics register, updated once per sample.
// Reset returns the statistics to zero and the registers to their defaults.
// A stalled report holds; the input register still takes a sample, and
// sample_stall rises only when both the input and the report registers are full.
`timescale 1ns / 1ps
`default_nettype none

module temperature_excursion_classifier
    import tec_pkg::*;
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   sample_valid,
    output logic                        sample_stall,
    input  tec_in_t                     sample,
    output logic                        report_valid,
    input  wire logic                   report_stall,
    output tec_out_t                    report,
    input  wire logic                   cfg_write,
    input  wire logic [CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  cfg_data
);

    tec_cfg_t   cfg;
    tec_state_t stats;
    tec_sev_t   severity;

    logic     in_valid_reg;
    tec_in_t  in_data_reg;
    logic     report_valid_reg;
    tec_out_t report_reg;

    logic     report_free;
    logic     advance;
    logic     sample_take;

    // The report register can load when it is empty or its content is being
    // taken in this cycle.
    assign report_free  = !report_valid_reg || !report_stall;
    assign advance      = in_valid_reg && report_free;
    assign sample_stall = in_valid_reg && !report_free;
    assign sample_take  = sample_valid && !sample_stall;

    tec_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    tec_stats u_stats (
        .clk     (clk),
        .rst_n   (rst_n),
        .advance (advance),
        .item    (in_data_reg),
        .cfg     (cfg),
        .stats   (stats)
    );

    tec_grade u_grade (
        .stats    (stats),
        .cfg      (cfg),
        .severity (severity)
    );

    // Input register: holds one sample until the report register can take it.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (!sample_stall)
            in_valid_reg <= sample_valid;
    end

    always_ff @(posedge clk)
    begin
        if (sample_take)
            in_data_reg <= sample;
    end

    // Report register: loaded with the updated statistics and grade.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            report_valid_reg <= 1'b0;
        else if (report_free)
            report_valid_reg <= advance;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            report_reg.sample_temp      <= in_data_reg.temperature;
            report_reg.highest_temp     <= stats.max_seen;
            report_reg.lowest_temp      <= stats.min_seen;
            report_reg.excursion_total  <= stats.minutes_accum;
            report_reg.excursion_events <= stats.event_count;
            report_reg.severity         <= severity;
        end
    end

    assign report_valid = report_valid_reg;
    assign report       = report_reg;

endmodule

`default_nettype wire

### rtl/tec_cfg.sv
// Configuration register file of the excursion classifier.
`timescale 1ns / 1ps
`default_nettype none

module tec_cfg
    import tec_pkg::*;
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   cfg_write,
    input  wire logic [CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  cfg_data,
    output tec_cfg_t                    cfg
);

    tec_cfg_t cfg_reg;
    tec_cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_write)
        begin
            case (tec_reg_idx_t'(cfg_index))
                REG_BAND_LOW:         cfg_next.band_low         = $signed(cfg_data);
                REG_BAND_HIGH:        cfg_next.band_high        = $signed(cfg_data);
                REG_WARN_MARGIN:      cfg_next.warn_margin      = cfg_data[14:0];
                REG_CRIT_MARGIN:      cfg_next.crit_margin      = cfg_data[14:0];
                REG_ALLOWED_MINUTES:  cfg_next.allowed_minutes  = cfg_data;
                REG_DELIVERY_MINUTES: cfg_next.delivery_minutes = cfg_data;
                REG_INTERVAL_MINUTES: cfg_next.interval_minutes = cfg_data[7:0];
                default:              cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.band_low         <= BAND_LOW_RST;
            cfg_reg.band_high        <= BAND_HIGH_RST;
            cfg_reg.warn_margin      <= WARN_MARGIN_RST;
            cfg_reg.crit_margin      <= CRIT_MARGIN_RST;
            cfg_reg.allowed_minutes  <= ALLOWED_MINUTES_RST;
            cfg_reg.delivery_minutes <= DELIVERY_MINUTES_RST;
            cfg_reg.interval_minutes <= INTERVAL_MINUTES_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

### rtl/tec_stats.sv
// Record statistics registers and their per-sample update.
`timescale 1ns / 1ps
`default_nettype none

module tec_stats
    import tec_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic advance,
    input  tec_in_t   item,
    input  tec_cfg_t  cfg,
    output tec_state_t stats
);

    tec_state_t state_reg;
    tec_state_t state_next;
    tec_state_t base;
    logic       outside;
    logic [16:0] minutes_sum;

    always_comb
    begin
        // A new record starts from this sample alone.
        if (item.first)
        begin
            base.min_seen      = item.temperature;
            base.max_seen      = item.temperature;
            base.was_outside   = 1'b0;
            base.minutes_accum = '0;
            base.event_count   = '0;
        end
        else
        begin
            base = state_reg;
            if (item.temperature < state_reg.min_seen)
                base.min_seen = item.temperature;
            if (item.temperature > state_reg.max_seen)
                base.max_seen = item.temperature;
        end

        outside     = (item.temperature < cfg.band_low) || (item.temperature > cfg.band_high);
        minutes_sum = {1'b0, base.minutes_accum} + {9'd0, cfg.interval_minutes};

        state_next             = base;
        state_next.was_outside = outside;
        if (outside)
        begin
            if (!base.was_outside && (base.event_count != COUNT_SAT))
                state_next.event_count = base.event_count + 16'd1;
            state_next.minutes_accum = minutes_sum[16] ? COUNT_SAT : minutes_sum[15:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= '0;
        else if (advance)
            state_reg <= state_next;
    end

    assign stats = state_next;

endmodule

`default_nettype wire

### rtl/tec_grade.sv
// Severity grading of the updated record statistics.
`timescale 1ns / 1ps
`default_nettype none

module tec_grade
    import tec_pkg::*;
(
    input  tec_state_t stats,
    input  tec_cfg_t   cfg,
    output tec_sev_t   severity
);

    logic [16:0] mag;
    logic [17:0] allow_x3;
    logic        over_allow;
    logic        crit;
    logic        high;

    always_comb
    begin
        // Distance of the highest sample beyond the band.
        mag = '0;
        if (stats.max_seen > cfg.band_high)
            mag = 17'($signed({stats.max_seen[15], stats.max_seen})
                      - $signed({cfg.band_high[15], cfg.band_high}));
        else if (stats.max_seen < cfg.band_low)
            mag = 17'($signed({cfg.band_low[15], cfg.band_low})
                      - $signed({stats.max_seen[15], stats.max_seen}));

        allow_x3   = {2'b00, cfg.allowed_minutes} + {1'b0, cfg.allowed_minutes, 1'b0};
        over_allow = stats.minutes_accum > cfg.allowed_minutes;

        crit = (mag >= {2'b00, cfg.crit_margin})
            || ({2'b00, stats.minutes_accum} >= allow_x3)
            || ((stats.event_count >= EVENTS_CRIT) && over_allow)
            || ((cfg.delivery_minutes < DELIVERY_CRIT_LIMIT) && over_allow);

        high = (mag >= {1'b0, cfg.warn_margin, 1'b0})
            || (stats.minutes_accum >= cfg.allowed_minutes)
            || (stats.event_count >= EVENTS_HIGH);

        if (stats.minutes_accum == '0)
            severity = SEV_NORMAL;
        else if (crit)
            severity = SEV_CRITICAL;
        else if (high)
            severity = SEV_HIGH;
        else
            severity = SEV_WARNING;
    end

endmodule

`default_nettype wire

### rtl/tec_checker.sv
// Port-level checker of the excursion classifier, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none

`include "temperature_excursion_classifier_assert.svh"

module tec_checker
    import tec_pkg::*;
(
    input wire logic clk,
    input wire logic rst_n,
    input wire logic sample_stall,
    input wire logic report_valid,
    input wire logic report_stall,
    input tec_out_t  report
);

    logic report_held;
    logic grade_normal;
    logic total_zero;
    logic temp_ordered;

    assign report_held  = report_valid && report_stall;
    assign grade_normal = (report.severity == SEV_NORMAL);
    assign total_zero   = (report.excursion_total == 16'd0);
    assign temp_ordered = ($signed(report.lowest_temp) <= $signed(report.sample_temp))
                       && ($signed(report.sample_temp) <= $signed(report.highest_temp));

    // A stalled report holds its content.
    `TEC_ASSERT_NEXT(a_report_hold, clk, rst_n, report_held, report_valid && $stable(report))

    // The input side stalls only while a finished report waits.
    `TEC_ASSERT_IMPLY(a_stall_cause, clk, rst_n, sample_stall, report_held)

    // Severity is normal exactly when no excursion minutes were counted.
    `TEC_ASSERT_IMPLY(a_normal_grade, clk, rst_n, report_valid, grade_normal == total_zero)

    // The sample lies between the lowest and highest of its record.
    `TEC_ASSERT_IMPLY(a_temp_order, clk, rst_n, report_valid, temp_ordered)

endmodule

bind temperature_excursion_classifier tec_checker u_tec_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .sample_stall (sample_stall),
    .report_valid (report_valid),
    .report_stall (report_stall),
    .report       (report)
);

`default_nettype wire

### sim/testbench.sv
// Self-checking testbench for the temperature excursion classifier.
`timescale 1ns / 1ps

module testbench
    import tec_pkg::*;
();

    // Timing of the run. The watchdog counts cycles in which no transfer happens on
    // either channel and no register is written, so it only trips on a real hang.
    localparam int CLK_HALF_NS          = 2;
    localparam int RESET_CYCLES         = 6;
    localparam int MAX_GAP              = 11;
    localparam int SETTLE_CYCLES        = 4;
    localparam int TAIL_CYCLES          = 8;
    localparam int HOLDOFF_LEN          = 64;
    localparam int WATCHDOG_LIMIT       = 4000;
    localparam int MISMATCH_PRINT_LIMIT = 10;
    localparam int RANDOM_PHASES        = 8;
    localparam int PHASE_SAMPLES        = 150;
    localparam int SATURATION_SAMPLES   = 269;

    // Multipliers used by the severity rules.
    localparam int MINUTES_CRIT_FACTOR = 3;
    localparam int MARGIN_HIGH_FACTOR  = 2;

    logic         clk;
    logic         rst_n;
    logic         sample_valid;
    logic         sample_stall;
    tec_in_t      sample;
    logic         report_valid;
    logic         report_stall;
    tec_out_t     report;
    logic         cfg_write;
    tec_reg_idx_t cfg_index;
    logic [15:0]  cfg_data;

    temperature_excursion_classifier dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .sample_valid (sample_valid),
        .sample_stall (sample_stall),
        .sample       (sample),
        .report_valid (report_valid),
        .report_stall (report_stall),
        .report       (report),
        .cfg_write    (cfg_write),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    // Register copy held by the predictor. It starts at the reset values of the block.
    logic signed [15:0] cfg_band_low  = BAND_LOW_RST;
    logic signed [15:0] cfg_band_high = BAND_HIGH_RST;
    logic [14:0]        cfg_warn      = WARN_MARGIN_RST;
    logic [14:0]        cfg_crit      = CRIT_MARGIN_RST;
    logic [15:0]        cfg_allowed   = ALLOWED_MINUTES_RST;
    logic [15:0]        cfg_delivery  = DELIVERY_MINUTES_RST;
    logic [7:0]         cfg_interval  = INTERVAL_MINUTES_RST;

    // Record statistics held by the predictor. All of them clear to zero at reset.
    logic signed [15:0] rec_lowest   = '0;
    logic signed [15:0] rec_highest  = '0;
    logic               rec_outside  = 1'b0;
    logic [15:0]        rec_minutes  = '0;
    logic [15:0]        rec_events   = '0;

    // Reports predicted for accepted samples and not yet seen on the output.
    tec_out_t pending_reports[$];

    // Pacing controls shared by the sender, the receiver and the tests.
    bit sender_gaps_on   = 1'b1;
    bit receiver_gaps_on = 1'b1;
    int holdoff_cycles   = 0;

    // Bookkeeping for the summary and the verdict.
    int mismatch_count    = 0;
    int samples_taken     = 0;
    int reports_checked   = 0;
    int cfg_writes_done   = 0;
    int input_stall_seen  = 0;
    int sev_count[4]      = '{0, 0, 0, 0};

    initial begin
        clk = 1'b0;
        forever #CLK_HALF_NS clk = ~clk;
    end

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    // Grades the record as it stands after the current sample. The magnitude is
    // always taken from the highest sample, even when the record went below the band.
    function automatic tec_sev_t grade_severity();
        int mag;
        int mins;
        int ev;
        int allow;
        mag   = 0;
        mins  = rec_minutes;
        ev    = rec_events;
        allow = cfg_allowed;
        if (mins == 0)
            return SEV_NORMAL;
        if (rec_highest > cfg_band_high)
            mag = int'(rec_highest) - int'(cfg_band_high);
        else if (rec_highest < cfg_band_low)
            mag = int'(cfg_band_low) - int'(rec_highest);

        if (mag >= int'(cfg_crit) || mins >= MINUTES_CRIT_FACTOR * allow ||
            (ev >= int'(EVENTS_CRIT) && mins > allow) ||
            (int'(cfg_delivery) < int'(DELIVERY_CRIT_LIMIT) && mins > allow))
            return SEV_CRITICAL;
        if (mag >= MARGIN_HIGH_FACTOR * int'(cfg_warn) || mins >= allow ||
            ev >= int'(EVENTS_HIGH))
            return SEV_HIGH;
        return SEV_WARNING;
    endfunction

    // Folds one accepted sample into the record statistics and returns the report
    // the block must produce for it.
    function automatic tec_out_t classify_sample(tec_in_t s);
        logic signed [15:0] t;
        logic               outside;
        logic [16:0]        sum;
        tec_out_t           r;
        t = s.temperature;
        if (s.first) begin
            // A new record starts from this sample alone.
            rec_lowest  = t;
            rec_highest = t;
            rec_outside = 1'b0;
            rec_minutes = '0;
            rec_events  = '0;
        end else begin
            if (t < rec_lowest)
                rec_lowest = t;
            if (t > rec_highest)
                rec_highest = t;
        end

        // The same two comparisons hold when the band is inverted.
        outside = (t < cfg_band_low) || (t > cfg_band_high);
        if (outside) begin
            // A new excursion starts only on the step from inside to outside.
            if (!rec_outside && rec_events != COUNT_SAT)
                rec_events = rec_events + 16'd1;
            sum = {1'b0, rec_minutes} + {9'd0, cfg_interval};
            rec_minutes = sum[16] ? COUNT_SAT : sum[15:0];
        end
        rec_outside = outside;

        r.sample_temp      = t;
        r.highest_temp     = rec_highest;
        r.lowest_temp      = rec_lowest;
        r.excursion_total  = rec_minutes;
        r.excursion_events = rec_events;
        r.severity         = grade_severity();
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Monitor and scoreboard
    // ------------------------------------------------------------------

    task automatic note_mismatch(string what, logic [15:0] want, logic [15:0] got);
        mismatch_count++;
        if (mismatch_count <= MISMATCH_PRINT_LIMIT)
            $display("Mismatch in %s at %0t ns: expected %h, got %h", what, $time, want, got);
    endtask

    // Both channels are sampled at the rising edge. Inputs only change at the falling
    // edge, so the values read here are the ones the block saw at this edge.
    always @(posedge clk) begin
        tec_out_t want;
        if (rst_n) begin
            if (sample_valid && sample_stall)
                input_stall_seen++;
            if (sample_valid && !sample_stall) begin
                pending_reports.insert(pending_reports.size(), classify_sample(sample));
                samples_taken++;
            end
            if (report_valid && !report_stall) begin
                reports_checked++;
                sev_count[report.severity]++;
                if (pending_reports.size() == 0) begin
                    note_mismatch("report with nothing pending", 16'h0000,
                                  report.sample_temp);
                end else begin
                    want = pending_reports.pop_front();
                    if (report.sample_temp !== want.sample_temp)
                        note_mismatch("sample_temp", want.sample_temp,
                                      report.sample_temp);
                    if (report.highest_temp !== want.highest_temp)
                        note_mismatch("highest_temp", want.highest_temp,
                                      report.highest_temp);
                    if (report.lowest_temp !== want.lowest_temp)
                        note_mismatch("lowest_temp", want.lowest_temp,
                                      report.lowest_temp);
                    if (report.excursion_total !== want.excursion_total)
                        note_mismatch("excursion_total", want.excursion_total,
                                      report.excursion_total);
                    if (report.excursion_events !== want.excursion_events)
                        note_mismatch("excursion_events", want.excursion_events,
                                      report.excursion_events);
                    if (report.severity !== want.severity)
                        note_mismatch("severity", {14'd0, want.severity},
                                      {14'd0, report.severity});
                end
            end
        end
    end

    // Watchdog: a long run of cycles without any transfer or register write means
    // the block has hung.
    always @(posedge clk) begin
        int quiet_cycles;
        if (!rst_n || cfg_write || (sample_valid && !sample_stall) ||
            (report_valid && !report_stall))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("Watchdog: no transfer for %0d cycles at %0t ns", quiet_cycles, $time);
            $display("temperature_excursion_classifier verification failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Report receiver
    // ------------------------------------------------------------------

    // Before each report the receiver stalls for a random number of cycles, or not
    // at all when its gaps are off. A requested hold-off replaces one such draw with a
    // long stretch so that the block fills up and pushes back on its input.
    initial begin
        int n;
        report_stall = 1'b0;
        @(negedge clk);
        forever begin
            if (holdoff_cycles != 0) begin
                n = holdoff_cycles;
                holdoff_cycles = 0;
            end else if (receiver_gaps_on) begin
                n = $urandom_range(0, MAX_GAP);
            end else begin
                n = 0;
            end
            if (n != 0) begin
                report_stall <= 1'b1;
                repeat (n) @(negedge clk);
            end
            report_stall <= 1'b0;
            do
                @(posedge clk);
            while (!(report_valid && !report_stall));
            @(negedge clk);
        end
    end

    // ------------------------------------------------------------------
    // Sample sender and register writes
    // ------------------------------------------------------------------

    // Offers one sample after a random gap and returns at the edge where it is
    // accepted. Valid stays high so that the next sample can follow back to back.
    task automatic send_sample(logic signed [15:0] t, logic f);
        int gap;
        gap = sender_gaps_on ? $urandom_range(0, MAX_GAP) : 0;
        @(negedge clk);
        if (gap != 0) begin
            sample_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        sample_valid <= 1'b1;
        sample       <= '{temperature: t, first: f};
        do
            @(posedge clk);
        while (!(sample_valid && !sample_stall));
    endtask

    // Stops offering samples and waits until every predicted report has come out.
    task automatic wait_drained();
        @(negedge clk);
        sample_valid <= 1'b0;
        while (pending_reports.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    // Writes one register and mirrors it into the predictor. Only called while the
    // block is idle, so the update order against samples does not matter.
    task automatic write_reg(tec_reg_idx_t idx, logic [15:0] value);
        @(negedge clk);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        case (idx)
            REG_BAND_LOW:         cfg_band_low  = value;
            REG_BAND_HIGH:        cfg_band_high = value;
            REG_WARN_MARGIN:      cfg_warn      = value[14:0];
            REG_CRIT_MARGIN:      cfg_crit      = value[14:0];
            REG_ALLOWED_MINUTES:  cfg_allowed   = value;
            REG_DELIVERY_MINUTES: cfg_delivery  = value;
            REG_INTERVAL_MINUTES: cfg_interval  = value[7:0];
            default: ;
        endcase
        cfg_writes_done++;
        @(negedge clk);
        cfg_write <= 1'b0;
    endtask

    // Drains the block and then writes every register.
    task automatic apply_settings(logic [15:0] band_lo, logic [15:0] band_hi,
                                  logic [15:0] warn, logic [15:0] crit,
                                  logic [15:0] allowed, logic [15:0] delivery,
                                  logic [15:0] interval);
        wait_drained();
        write_reg(REG_BAND_LOW, band_lo);
        write_reg(REG_BAND_HIGH, band_hi);
        write_reg(REG_WARN_MARGIN, warn);
        write_reg(REG_CRIT_MARGIN, crit);
        write_reg(REG_ALLOWED_MINUTES, allowed);
        write_reg(REG_DELIVERY_MINUTES, delivery);
        write_reg(REG_INTERVAL_MINUTES, interval);
    endtask

    // ------------------------------------------------------------------
    // Random content
    // ------------------------------------------------------------------

    function automatic logic signed [15:0] to_temp(int v);
        if (v < -32768)
            return 16'sh8000;
        if (v > 32767)
            return 16'sh7FFF;
        return v[15:0];
    endfunction

    // Most samples fall around the band so that records move in and out of it and
    // reach every severity. The rest are band edges, range extremes and raw noise.
    function automatic logic signed [15:0] pick_temperature();
        int          lo;
        int          hi;
        int          span;
        int          base;
        logic [31:0] raw;
        lo = cfg_band_low;
        hi = cfg_band_high;
        if (lo > hi) begin
            base = lo;
            lo   = hi;
            hi   = base;
        end
        span = int'(cfg_crit) + int'(cfg_warn) + 16;
        case ($urandom_range(0, 9))
            0, 1: begin
                raw = $urandom;
                return raw[15:0];
            end
            2: begin
                case ($urandom_range(0, 5))
                    0: return cfg_band_low;
                    1: return to_temp(int'(cfg_band_low) - 1);
                    2: return cfg_band_high;
                    3: return to_temp(int'(cfg_band_high) + 1);
                    4: return 16'sh8000;
                    default: return 16'sh7FFF;
                endcase
            end
            default: begin
                base = lo - span;
                return to_temp(base + int'($urandom_range(0, hi + span - base)));
            end
        endcase
    endfunction

    // Picks a register set for one random phase. The first few phases pin the
    // extremes; the others draw moderate values that make every rule reachable.
    task automatic apply_phase_settings(int phase);
        int bl;
        int bh;
        case (phase)
            0: apply_settings(16'h8000, 16'h7FFF, 16'h0000, 16'h0000,
                              16'h0000, 16'h0000, 16'h0001);
            1: apply_settings(16'h7FFF, 16'h8000, 16'h7FFF, 16'hFFFF,
                              16'hFFFF, 16'hFFFF, 16'h00FF);
            default: begin
                bl = int'($urandom_range(0, 640)) - 320;
                bh = bl + int'($urandom_range(0, 480)) - 40;
                apply_settings(to_temp(bl), to_temp(bh),
                               16'($urandom_range(0, 80)),
                               16'($urandom_range(0, 240)),
                               16'($urandom_range(0, 200)),
                               (phase == 2) ? 16'd119 :
                               (phase == 3) ? 16'd120 : 16'($urandom_range(60, 300)),
                               (phase == 4) ? 16'd0 : 16'($urandom_range(1, 80)));
            end
        endcase
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Without a first flag the earliest samples merge into the cleared statistics,
    // so zero still counts as a lowest and a highest value.
    task automatic test_merge_after_reset();
        send_sample(16'sd200, 1'b0);
        send_sample(-16'sd50, 1'b0);
        send_sample(16'sd60, 1'b0);
        send_sample(16'sd20, 1'b0);
        send_sample(16'sd100, 1'b0);
    endtask

    // Full-range temperatures and the samples on and just beyond each band edge.
    task automatic test_field_extremes();
        send_sample(16'sh7FFF, 1'b1);
        send_sample(16'sh8000, 1'b0);
        send_sample(16'sd0, 1'b0);
        send_sample(-16'sd1, 1'b0);
        send_sample(16'sh8000, 1'b1);
        send_sample(16'sh7FFF, 1'b0);
        send_sample(16'sd32, 1'b1);
        send_sample(16'sd31, 1'b0);
        send_sample(16'sd128, 1'b0);
        send_sample(16'sd129, 1'b0);
        send_sample(16'sd127, 1'b0);
        send_sample(16'sd33, 1'b0);
    endtask

    // Walks a record up through warning, high and critical, then shows the short
    // delivery rule on its own.
    task automatic test_severity_levels();
        apply_settings(16'd32, 16'd128, 16'd16, 16'd48, 16'd30, 16'd180, 16'd10);
        send_sample(16'sd80, 1'b1);
        send_sample(16'sd135, 1'b0);
        send_sample(16'sd100, 1'b0);
        send_sample(16'sd140, 1'b0);
        send_sample(16'sd170, 1'b0);
        send_sample(16'sd190, 1'b0);
        send_sample(16'sd20, 1'b1);
        send_sample(16'sd10, 1'b0);
        send_sample(16'sd100, 1'b1);
        apply_settings(16'd32, 16'd128, 16'd16, 16'd48, 16'd30, 16'd100, 16'd10);
        send_sample(16'sd140, 1'b1);
        send_sample(16'sd140, 1'b0);
        send_sample(16'sd140, 1'b0);
        send_sample(16'sd140, 1'b0);
    endtask

    // With a zero interval excursions are still counted but add no minutes.
    task automatic test_zero_interval();
        apply_settings(16'd32, 16'd128, 16'd16, 16'd48, 16'd30, 16'd180, 16'd0);
        send_sample(16'sd200, 1'b1);
        send_sample(16'sd80, 1'b0);
        send_sample(16'sd200, 1'b0);
        send_sample(-16'sd10, 1'b0);
        send_sample(16'sd80, 1'b0);
    endtask

    // An inverted band puts every sample outside.
    task automatic test_inverted_band();
        apply_settings(16'd200, 16'd50, 16'd16, 16'd48, 16'd30, 16'd180, 16'd5);
        send_sample(16'sd100, 1'b1);
        send_sample(16'sd300, 1'b0);
        send_sample(-16'sd100, 1'b0);
        send_sample(16'sd50, 1'b0);
        send_sample(16'sd200, 1'b0);
    endtask

    // The sender stops until the block is empty, then continues the same record, so
    // the statistics must survive an idle stretch.
    task automatic test_drain_pause();
        int i;
        apply_settings(16'd32, 16'd128, 16'd16, 16'd48, 16'd90, 16'd180, 16'd7);
        send_sample(pick_temperature(), 1'b1);
        for (i = 0; i < 9; i++)
            send_sample(pick_temperature(), 1'b0);
        wait_drained();
        for (i = 0; i < 10; i++)
            send_sample(pick_temperature(), 1'b0);
    endtask

    // The receiver holds off for a long stretch while samples keep coming back to
    // back, so the block fills and stalls its input.
    task automatic test_backpressure();
        int i;
        wait_drained();
        sender_gaps_on = 1'b0;
        holdoff_cycles = HOLDOFF_LEN;
        send_sample(pick_temperature(), 1'b1);
        for (i = 0; i < 23; i++)
            send_sample(pick_temperature(), 1'b0);
        wait_drained();
        sender_gaps_on = 1'b1;
    endtask

    // Keeps one record outside the band long enough for the minute total to reach
    // its ceiling and stay there.
    task automatic test_saturation();
        int i;
        apply_settings(16'd0, 16'd0, 16'h7FFF, 16'h7FFF, 16'hFFFF, 16'hFFFF, 16'd255);
        sender_gaps_on   = 1'b0;
        receiver_gaps_on = 1'b0;
        send_sample(16'sd100, 1'b1);
        for (i = 0; i < SATURATION_SAMPLES; i++)
            send_sample(16'sd100, 1'b0);
        wait_drained();
        sender_gaps_on   = 1'b1;
        receiver_gaps_on = 1'b1;
    endtask

    // Random records under several register sets. The phases vary the pacing: some
    // run the sender or the receiver without gaps, but none runs both without gaps.
    task automatic test_random_records();
        int phase;
        int i;
        int record_left;
        logic f;
        for (phase = 0; phase < RANDOM_PHASES; phase++) begin
            apply_phase_settings(phase);
            sender_gaps_on   = (phase % 3) != 0;
            receiver_gaps_on = (phase % 4) != 1;
            record_left      = 0;
            for (i = 0; i < PHASE_SAMPLES; i++) begin
                // Mostly well-formed records; now and then a stray first flag.
                f = (record_left == 0) || ($urandom_range(0, 19) == 0);
                if (f)
                    record_left = $urandom_range(1, 40);
                record_left--;
                send_sample(pick_temperature(), f);
            end
        end
        wait_drained();
        sender_gaps_on   = 1'b1;
        receiver_gaps_on = 1'b1;
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------

    initial begin
        rst_n        = 1'b0;
        sample_valid = 1'b0;
        sample       = '0;
        cfg_write    = 1'b0;
        cfg_index    = REG_BAND_LOW;
        cfg_data     = '0;
        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_merge_after_reset();
        test_field_extremes();
        test_severity_levels();
        test_zero_interval();
        test_inverted_band();
        test_drain_pause();
        test_backpressure();
        test_random_records();
        test_saturation();

        wait_drained();
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("Covered %0d samples, %0d reports, %0d register writes, %0d stalled offers.",
                 samples_taken, reports_checked, cfg_writes_done, input_stall_seen);
        $display("Severities seen: normal %0d, warning %0d, high %0d, critical %0d.",
                 sev_count[SEV_NORMAL], sev_count[SEV_WARNING],
                 sev_count[SEV_HIGH], sev_count[SEV_CRITICAL]);
        if (mismatch_count == 0 && pending_reports.size() == 0)
            $display("temperature_excursion_classifier verification clean");
        else
            $display("temperature_excursion_classifier verification failed");
        $finish;
    end

endmodule
